### sv/bal_pkg.sv
// Shared types and constants of the bounded array list.
`timescale 1ns / 1ps
package bal_pkg;

  localparam int FuncW = 4;
  localparam int DataW = 32;
  localparam int PosW  = 7;
  localparam int OutW  = 8;

  localparam logic [OutW-1:0] NoIndex = 8'hFF;

  typedef logic [DataW-1:0] data_t;

  typedef enum logic [FuncW-1:0] {
    OP_INS_FIRST      = 4'd0,
    OP_INS_LAST       = 4'd1,
    OP_INS_AT         = 4'd2,
    OP_SEARCH         = 4'd3,
    OP_RM_FIRST       = 4'd4,
    OP_RM_LAST        = 4'd5,
    OP_RM_AT          = 4'd6,
    OP_RM_MATCH_FIRST = 4'd7,
    OP_RM_MATCH_LAST  = 4'd8,
    OP_RM_ALL         = 4'd9,
    OP_REPLACE        = 4'd10,
    OP_CLEAR          = 4'd11
  } func_e;

  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_LOAD,
    CMD_SHR,
    CMD_SHL
  } cmd_e;

  typedef struct packed {
    logic cmp;
    cmd_e cmd;
  } cell_ctl_t;

  typedef struct packed {
    logic            ok;
    logic            more;
    logic [OutW-1:0] found;
  } exec_res_t;

endpackage

### sv/bal_if.sv
// Handshake interfaces for the operation and result channels.
`timescale 1ns / 1ps
interface bal_in_if;
  logic               valid;
  logic               ready;
  logic [3:0]         func;
  logic signed [31:0] value;
  logic [6:0]         position;
  logic signed [31:0] new_value;

  modport source (output valid, func, value, position, new_value, input ready);
  modport sink (input valid, func, value, position, new_value, output ready);
endinterface

interface bal_out_if;
  logic              valid;
  logic              ready;
  logic              ok;
  logic signed [7:0] found_index;
  logic [7:0]        count;
  logic              full_res;
  logic              empty_res;

  modport source (output valid, ok, found_index, count, full_res, empty_res, input ready);
  modport sink (input valid, ok, found_index, count, full_res, empty_res, output ready);
endinterface

### sv/bounded_array_list.sv
// Top level of the bounded array list: a row of element cells under a small sequencer.
// The result is registered after the compare, execute and result states that follow the
// input transfer; a new operation is taken only once the last result is registered,
// and a result left waiting at the output holds the sequencer until it goes. Removing all
// matches repeats a compare pass over the cell row and a shift step per element removed.
// Reset clears the element count and the control state; element storage is not cleared.
`timescale 1ns / 1ps
module bounded_array_list #(
  parameter int CAPACITY = 128
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  bal_in_if.sink            in_i,
  bal_out_if.source         out_o
);
  import bal_pkg::*;

  localparam int CntW = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_EXEC,
    ST_RES
  } state_e;

  state_e          state_q;
  logic [CntW-1:0] cnt_q;
  logic [CntW-1:0] cnt_d;
  logic            ok_q;
  logic [OutW-1:0] found_q;
  logic            out_valid_q;
  logic            out_ok_q;
  logic [OutW-1:0] out_found_q;
  logic [OutW-1:0] out_count_q;
  logic            out_full_q;
  logic            out_empty_q;

  logic [FuncW-1:0] op_q;
  data_t            val_q;
  logic [PosW-1:0]  pos_q;
  data_t            nv_q;

  func_e            op;
  data_t            load_data;
  logic             in_xfer;
  cmd_e             cmd [CAPACITY];
  cell_ctl_t        ctl [CAPACITY];
  data_t            cell_data [CAPACITY];
  logic [CAPACITY-1:0] cell_eq;
  exec_res_t        res;

  assign op        = func_e'(op_q);
  assign load_data = (op == OP_REPLACE) ? nv_q : val_q;
  assign in_i.ready = (state_q == ST_IDLE);
  assign in_xfer    = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      op_q  <= in_i.func;
      val_q <= in_i.value;
      pos_q <= in_i.position;
      nv_q  <= in_i.new_value;
    end
  end

  bal_ctrl #(
    .Capacity (CAPACITY),
    .CntW     (CntW)
  ) u_ctrl (
    .op_i  (op),
    .pos_i (pos_q),
    .cnt_i (cnt_q),
    .eq_i  (cell_eq),
    .cmd_o (cmd),
    .cnt_o (cnt_d),
    .res_o (res)
  );

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cells
    data_t left_data;
    data_t right_data;

    if (i == 0) begin : g_first
      assign left_data = cell_data[i];
    end else begin : g_mid_l
      assign left_data = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_data = cell_data[i];
    end else begin : g_mid_r
      assign right_data = cell_data[i+1];
    end

    assign ctl[i] = '{cmp: (state_q == ST_CMP),
                      cmd: (state_q == ST_EXEC) ? cmd[i] : CMD_HOLD};

    bal_cell u_cell (
      .clk_i   (clk_i),
      .ctl_i   (ctl[i]),
      .left_i  (left_data),
      .right_i (right_data),
      .load_i  (load_data),
      .key_i   (val_q),
      .data_o  (cell_data[i]),
      .eq_o    (cell_eq[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      ok_q        <= 1'b0;
      found_q     <= NoIndex;
      out_valid_q <= 1'b0;
      out_ok_q    <= 1'b0;
      out_found_q <= NoIndex;
      out_count_q <= '0;
      out_full_q  <= 1'b0;
      out_empty_q <= 1'b1;
    end else begin
      if (out_o.ready && (state_q != ST_RES)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_xfer) begin
            ok_q    <= 1'b0;
            state_q <= ST_CMP;
          end
        end
        ST_CMP: begin
          state_q <= ST_EXEC;
        end
        ST_EXEC: begin
          cnt_q   <= cnt_d;
          ok_q    <= ok_q | res.ok;
          found_q <= res.found;
          state_q <= res.more ? ST_CMP : ST_RES;
        end
        ST_RES: begin
          if (!out_valid_q || out_o.ready) begin
            out_valid_q <= 1'b1;
            out_ok_q    <= ok_q;
            out_found_q <= found_q;
            out_count_q <= OutW'(cnt_q);
            out_full_q  <= (cnt_q == CntW'(CAPACITY));
            out_empty_q <= (cnt_q == '0);
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.ok          = out_ok_q;
  assign out_o.found_index = out_found_q;
  assign out_o.count       = out_count_q;
  assign out_o.full_res    = out_full_q;
  assign out_o.empty_res   = out_empty_q;

endmodule

### sv/bal_cell.sv
// One storage cell of the list: holds an element, shifts to either neighbour and compares.
`timescale 1ns / 1ps
module bal_cell (
  input  logic                clk_i,
  input  bal_pkg::cell_ctl_t  ctl_i,
  input  bal_pkg::data_t      left_i,
  input  bal_pkg::data_t      right_i,
  input  bal_pkg::data_t      load_i,
  input  bal_pkg::data_t      key_i,
  output bal_pkg::data_t      data_o,
  output logic                eq_o
);
  import bal_pkg::*;

  data_t data_q, data_d;
  logic  eq_q;

  always_comb begin
    unique case (ctl_i.cmd)
      CMD_HOLD: data_d = data_q;
      CMD_LOAD: data_d = load_i;
      CMD_SHR:  data_d = left_i;
      CMD_SHL:  data_d = right_i;
      default:  data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    if (ctl_i.cmp) begin
      eq_q <= (data_q == key_i);
    end
  end

  assign data_o = data_q;
  assign eq_o   = eq_q;

endmodule

### sv/bal_ctrl.sv
// Decodes one operation into per-cell shift and load commands and the new element count.
`timescale 1ns / 1ps
module bal_ctrl #(
  parameter int Capacity = 128,
  parameter int CntW     = $clog2(Capacity + 1)
) (
  input  bal_pkg::func_e                 op_i,
  input  logic [bal_pkg::PosW-1:0]       pos_i,
  input  logic [CntW-1:0]                cnt_i,
  input  logic [Capacity-1:0]            eq_i,
  output bal_pkg::cmd_e                  cmd_o [Capacity],
  output logic [CntW-1:0]                cnt_o,
  output bal_pkg::exec_res_t             res_o
);
  import bal_pkg::*;

  localparam int PW   = (CntW > PosW) ? CntW : PosW;
  localparam int IdxW = (Capacity > 1) ? $clog2(Capacity) : 1;

  logic [PW-1:0]       cnt_x;
  logic [PW-1:0]       ins_p;
  logic [PW-1:0]       rm_p;
  logic [Capacity-1:0] eqv;
  logic [Capacity-1:0] pre_lo;
  logic [Capacity-1:0] post_hi;
  logic [Capacity-1:0] first_hit;
  logic [Capacity-1:0] last_hit;
  logic                any_hit;
  logic                can_ins;
  logic                can_rm;
  logic [IdxW-1:0]     last_idx;

  always_comb begin
    cnt_x = PW'(cnt_i);
    for (int i = 0; i < Capacity; i++) begin
      eqv[i] = eq_i[i] && (PW'(i) < cnt_x);
    end
    any_hit = |eqv;

    pre_lo = eqv;
    for (int k = 1; k < Capacity; k = k * 2) begin
      pre_lo = pre_lo | (pre_lo << k);
    end
    post_hi = eqv >> 1;
    for (int k = 1; k < Capacity; k = k * 2) begin
      post_hi = post_hi | (post_hi >> k);
    end
    first_hit = eqv & ~(pre_lo << 1);
    last_hit  = eqv & ~post_hi;

    last_idx = '0;
    for (int i = 0; i < Capacity; i++) begin
      if (last_hit[i]) begin
        last_idx = last_idx | IdxW'(i);
      end
    end

    unique case (op_i)
      OP_INS_FIRST: ins_p = '0;
      OP_INS_LAST:  ins_p = cnt_x;
      default:      ins_p = PW'(pos_i);
    endcase
    rm_p    = (op_i == OP_RM_AT) ? PW'(pos_i) : '0;
    can_ins = (cnt_x < PW'(Capacity)) && (ins_p <= cnt_x);
    can_rm  = rm_p < cnt_x;

    for (int i = 0; i < Capacity; i++) begin
      cmd_o[i] = CMD_HOLD;
    end
    cnt_o = cnt_i;
    res_o = '{ok: 1'b0, more: 1'b0, found: NoIndex};

    unique case (op_i)
      OP_INS_FIRST, OP_INS_LAST, OP_INS_AT: begin
        res_o.ok = can_ins;
        if (can_ins) begin
          for (int i = 0; i < Capacity; i++) begin
            if (PW'(i) == ins_p) begin
              cmd_o[i] = CMD_LOAD;
            end else if ((PW'(i) > ins_p) && (PW'(i) <= cnt_x)) begin
              cmd_o[i] = CMD_SHR;
            end
          end
          cnt_o = cnt_i + 1'b1;
        end
      end
      OP_SEARCH: begin
        res_o.ok = any_hit;
        if (any_hit) begin
          res_o.found = OutW'(last_idx);
        end
      end
      OP_RM_FIRST, OP_RM_AT: begin
        res_o.ok = can_rm;
        if (can_rm) begin
          for (int i = 0; i < Capacity; i++) begin
            if (PW'(i) >= rm_p) begin
              cmd_o[i] = CMD_SHL;
            end
          end
          cnt_o = cnt_i - 1'b1;
        end
      end
      OP_RM_LAST: begin
        res_o.ok = (cnt_i != '0);
        if (cnt_i != '0) begin
          cnt_o = cnt_i - 1'b1;
        end
      end
      OP_RM_MATCH_FIRST, OP_RM_ALL: begin
        res_o.ok   = any_hit;
        res_o.more = any_hit && (op_i == OP_RM_ALL);
        if (any_hit) begin
          for (int i = 0; i < Capacity; i++) begin
            if (pre_lo[i]) begin
              cmd_o[i] = CMD_SHL;
            end
          end
          cnt_o = cnt_i - 1'b1;
        end
      end
      OP_RM_MATCH_LAST: begin
        res_o.ok = any_hit;
        if (any_hit) begin
          for (int i = 0; i < Capacity; i++) begin
            if (!post_hi[i]) begin
              cmd_o[i] = CMD_SHL;
            end
          end
          cnt_o = cnt_i - 1'b1;
        end
      end
      OP_REPLACE: begin
        res_o.ok = any_hit;
        for (int i = 0; i < Capacity; i++) begin
          if (first_hit[i]) begin
            cmd_o[i] = CMD_LOAD;
          end
        end
      end
      OP_CLEAR: begin
        res_o.ok = 1'b1;
        cnt_o    = '0;
      end
      default: begin
        res_o.ok = 1'b0;
      end
    endcase
  end

endmodule
